[hdl/smf_pkg.sv]
// Shared types and constants for the running median filter.
// Used by smf_cell and sliding_window_median_filter_top; no dependencies.
package smf_pkg;

  // Fixed widths of the sample and median ports
  localparam int unsigned SAMPLE_PORT_W = 16;
  localparam int unsigned MEDIAN_PORT_W = 16;

  // Operation codes carried on the operation field
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Per-cycle command broadcast to every cell of the sorted chain
  typedef struct packed {
    logic load;   // insert a new sample, drop the oldest entry
    logic clear;  // zero all entries and restart the age order
  } cell_ctl_t;

endpackage

[hdl/smf_cell.sv]
// One cell of the sorted window chain: holds a sample and its age.
// Depends on smf_pkg; instantiated in a row by sliding_window_median_filter_top.
module smf_cell
  import smf_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned AGE_W       = 3,
  parameter int unsigned INDEX       = 0,
  parameter int unsigned LAST_AGE    = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cell_ctl_t              ctl_i,
  input  logic [SAMPLE_BITS-1:0] new_val_i,
  // neighbor below (smaller values)
  input  logic [SAMPLE_BITS-1:0] lo_val_i,
  input  logic [AGE_W-1:0]       lo_age_i,
  input  logic                   lo_gt_i,
  // neighbor above (larger values)
  input  logic [SAMPLE_BITS-1:0] hi_val_i,
  input  logic [AGE_W-1:0]       hi_age_i,
  input  logic                   hi_gt_i,
  // oldest entry sits in some cell below this one
  input  logic                   del_below_i,
  output logic                   del_upto_o,
  output logic                   gt_o,
  output logic                   oldest_o,
  output logic [SAMPLE_BITS-1:0] val_o,
  output logic [AGE_W-1:0]       age_o,
  output logic [SAMPLE_BITS-1:0] val_d_o
);

  logic [SAMPLE_BITS-1:0] val_q, val_d;
  logic [AGE_W-1:0]       age_q, age_d;
  logic                   is_del;

  // Compare against the incoming sample and flag the oldest entry
  assign gt_o       = val_q > new_val_i;
  assign is_del     = age_q == AGE_W'(LAST_AGE);
  assign del_upto_o = del_below_i | is_del;
  assign oldest_o   = is_del;
  assign val_o      = val_q;
  assign age_o      = age_q;
  assign val_d_o    = val_d;

  // Pick this cell's next entry: keep, take a neighbor's, or take the new sample
  always_comb begin
    val_d = val_q;
    age_d = age_q;
    if (ctl_i.clear) begin
      val_d = '0;
      age_d = AGE_W'(INDEX);
    end else if (ctl_i.load) begin
      if (!del_below_i && !is_del) begin
        // oldest entry lies above this cell
        if (!gt_o) begin
          val_d = val_q;
          age_d = age_q + 1'b1;
        end else if (!lo_gt_i) begin
          val_d = new_val_i;
          age_d = '0;
        end else begin
          val_d = lo_val_i;
          age_d = lo_age_i + 1'b1;
        end
      end else begin
        // oldest entry is here or below: contents close up from above
        if (!hi_gt_i) begin
          val_d = hi_val_i;
          age_d = hi_age_i + 1'b1;
        end else if (is_del) begin
          if (lo_gt_i) begin
            val_d = lo_val_i;
            age_d = lo_age_i + 1'b1;
          end else begin
            val_d = new_val_i;
            age_d = '0;
          end
        end else if (gt_o) begin
          val_d = val_q;
          age_d = age_q + 1'b1;
        end else begin
          val_d = new_val_i;
          age_d = '0;
        end
      end
    end
  end

  // Hold the entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      age_q <= AGE_W'(INDEX);
    end else begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

endmodule

[hdl/sliding_window_median_filter_top.sv]
// Running median filter: top level with the sorted cell chain and output register.
// Depends on smf_pkg and smf_cell.
//
//  channel | handshake                    | payload
//  --------+------------------------------+----------------------------------
//  in      | in_valid_i / in_stall_o      | operation_i, sample_i
//  out     | out_valid_o / out_stall_i    | median_o
//
// One item per cycle unless in_stall_o: the cells update the sorted window in
// the transaction's cycle and the output register holds its median next cycle.
// The per-cycle path is the compare in every cell plus a ripple of the
// "oldest entry below" flag through WINDOW cells.
// Reset zeroes the window; no clearing pass is needed.
// in_stall_o rises only while a result waits and out_stall_i is high.
module sliding_window_median_filter_top
  import smf_pkg::*;
#(
  parameter int unsigned WINDOW      = 5,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     operation_i,
  input  logic [SAMPLE_PORT_W-1:0] sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [MEDIAN_PORT_W-1:0] median_o
);

  localparam int unsigned AGE_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned MEDIAN_RANK = (WINDOW - 1) / 2;

  logic                   in_accept;
  cell_ctl_t              ctl;
  logic [SAMPLE_BITS-1:0] new_val;
  logic [SAMPLE_BITS-1:0] val   [WINDOW];
  logic [SAMPLE_BITS-1:0] val_d [WINDOW];
  logic [AGE_W-1:0]       age   [WINDOW];
  logic [WINDOW-1:0]      gt;
  logic [WINDOW-1:0]      del_upto;
  logic [WINDOW-1:0]      oldest;
  logic [WINDOW-1:0]      order_ok;

  logic                     out_valid_q;
  logic [MEDIAN_PORT_W-1:0] median_q;

  // Accept while the output register is empty or being drained
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign ctl.load   = in_accept & (operation_i == OP_SAMPLE);
  assign ctl.clear  = in_accept & (operation_i == OP_CLEAR);
  assign new_val    = SAMPLE_BITS'(sample_i);

  // Build the row of cells, smallest value in cell 0
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] lo_val, hi_val;
    logic [AGE_W-1:0]       lo_age, hi_age;
    logic                   lo_gt, hi_gt, del_below;

    if (i == 0) begin : g_bottom
      assign lo_val    = '0;
      assign lo_age    = '0;
      assign lo_gt     = 1'b0;
      assign del_below = 1'b0;
    end else begin : g_lo
      assign lo_val    = val[i-1];
      assign lo_age    = age[i-1];
      assign lo_gt     = gt[i-1];
      assign del_below = del_upto[i-1];
    end

    if (i == WINDOW - 1) begin : g_top
      assign hi_val      = '0;
      assign hi_age      = '0;
      assign hi_gt       = 1'b1;
      assign order_ok[i] = 1'b1;
    end else begin : g_hi
      assign hi_val      = val[i+1];
      assign hi_age      = age[i+1];
      assign hi_gt       = gt[i+1];
      assign order_ok[i] = val[i] <= val[i+1];
    end

    smf_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_W       (AGE_W),
      .INDEX       (i),
      .LAST_AGE    (WINDOW - 1)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .new_val_i   (new_val),
      .lo_val_i    (lo_val),
      .lo_age_i    (lo_age),
      .lo_gt_i     (lo_gt),
      .hi_val_i    (hi_val),
      .hi_age_i    (hi_age),
      .hi_gt_i     (hi_gt),
      .del_below_i (del_below),
      .del_upto_o  (del_upto[i]),
      .gt_o        (gt[i]),
      .oldest_o    (oldest[i]),
      .val_o       (val[i]),
      .age_o       (age[i]),
      .val_d_o     (val_d[i])
    );
  end

  // Register the median of the updated window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      median_q <= MEDIAN_PORT_W'(val_d[MEDIAN_RANK]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

  // Exactly one entry is the oldest at any time
  a_one_oldest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(oldest))
    else $error("oldest entry not unique");

  // The chain stays sorted ascending
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    &order_ok)
    else $error("cell chain out of order");

  // Every accepted transaction yields a result in the next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("missing result");

  // A clear returns zero
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.clear |=> median_o == '0)
    else $error("clear did not return zero");

endmodule
